FILE: sv/tcec_pkg.sv
// Shared types and constants of the two-car elevator controller.
`timescale 1ns / 1ps
`default_nettype none
package tcec_pkg;
    localparam int QUEUE_DEPTH  = 8;
    localparam int FLOOR_BITS   = 4;
    localparam int TICKS_PER_SEC = 15000;
    localparam logic [15:0] TRAVEL_RESET = 16'(4 * TICKS_PER_SEC);
    localparam logic [15:0] OPEN_RESET   = 16'(3 * TICKS_PER_SEC);
    localparam logic [15:0] CLOSE_RESET  = 16'(3 * TICKS_PER_SEC / 2);

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_HALL = 2'd1;
    localparam logic [1:0] KIND_CAR  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;

    localparam logic [1:0] CFG_TRAVEL = 2'd0;
    localparam logic [1:0] CFG_OPEN   = 2'd1;
    localparam logic [1:0] CFG_CLOSE  = 2'd2;

    localparam logic [1:0] SHOW_OPEN   = 2'd0;
    localparam logic [1:0] SHOW_CLOSED = 2'd1;
    localparam logic [1:0] SHOW_UP     = 2'd2;
    localparam logic [1:0] SHOW_DOWN   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE, PH_START_UP, PH_START_DOWN, PH_GO_UP, PH_GO_DOWN, PH_STOP
    } t_phase;

    // Timer settings handed to each car.
    typedef struct packed {
        logic [15:0] travel;
        logic [15:0] open;
        logic [15:0] close;
    } t_timing;

    // One operation presented to a car in the current cycle.
    typedef struct packed {
        logic tick;
        logic add;
    } t_car_op;
endpackage
`default_nettype wire

FILE: sv/tcec_car.sv
// One elevator car: phase, floor, timer and ordered request list.
`timescale 1ns / 1ps
`default_nettype none
module tcec_car #(
    parameter int QDEPTH = tcec_pkg::QUEUE_DEPTH,
    parameter int FBITS  = tcec_pkg::FLOOR_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tcec_pkg::t_timing     i_timing,
    input  tcec_pkg::t_car_op     i_op,
    input  wire [FBITS-1:0]       i_floor,
    output logic                  o_added,
    output tcec_pkg::t_phase      o_phase,
    output logic [FBITS-1:0]      o_position,
    output logic [1:0]            o_show,
    output logic [$clog2(QDEPTH+1)-1:0] o_count
);
    import tcec_pkg::*;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam int IW = $clog2(QDEPTH);

    t_phase                r_phase, n_phase;
    logic [FBITS-1:0]      r_pos, n_pos;
    logic [1:0]            r_show, n_show;
    logic [15:0]           r_timer, n_timer;
    logic                  r_closed, n_closed;
    logic [CW-1:0]         r_count, n_count;
    logic [FBITS-1:0]      r_list [QDEPTH];
    logic [FBITS-1:0]      n_list [QDEPTH];
    logic [15:0]           timer_inc;
    logic                  dup;
    logic [FBITS-1:0]      first;
    logic [CW-1:0]         wr;

    assign timer_inc = r_timer + 16'd1;
    assign first = r_list[0];

    // Duplicate search over the live entries.
    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < QDEPTH; i++) begin
            if (CW'(i) < r_count && r_list[i] == i_floor) dup = 1'b1;
        end
    end

    // Next state for a tick or an added call.
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_show   = r_show;
        n_timer  = r_timer;
        n_closed = r_closed;
        n_count  = r_count;
        n_list   = r_list;
        o_added  = 1'b0;
        wr       = '0;
        if (i_op.add) begin
            if (!dup) begin
                if (r_count == '0) begin
                    o_added  = 1'b1;
                    n_timer  = '0;
                    n_closed = 1'b0;
                    n_show   = SHOW_OPEN;
                    if (i_floor == r_pos) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_list[0] = i_floor;
                        n_count   = CW'(1);
                        n_phase   = (i_floor < r_pos) ? PH_START_DOWN : PH_START_UP;
                    end
                end else if (r_count < CW'(QDEPTH)) begin
                    o_added = 1'b1;
                    n_list[r_count[IW-1:0]] = i_floor;
                    n_count = r_count + CW'(1);
                end
            end
        end else if (i_op.tick) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_show  = SHOW_OPEN;
                    n_timer = '0;
                end
                PH_START_UP, PH_START_DOWN: begin
                    n_timer = timer_inc;
                    if (!r_closed) begin
                        if (timer_inc >= i_timing.open) begin
                            n_closed = 1'b1;
                            n_timer  = '0;
                            n_show   = SHOW_CLOSED;
                        end
                    end else if (timer_inc >= i_timing.close) begin
                        n_timer  = '0;
                        n_closed = 1'b0;
                        n_phase  = (r_phase == PH_START_UP) ? PH_GO_UP : PH_GO_DOWN;
                        n_show   = (r_phase == PH_START_UP) ? SHOW_UP : SHOW_DOWN;
                    end
                end
                PH_GO_UP, PH_GO_DOWN: begin
                    n_timer = timer_inc;
                    if (timer_inc >= i_timing.travel) begin
                        n_timer = '0;
                        n_pos = (r_phase == PH_GO_UP) ? r_pos + FBITS'(1)
                                                      : r_pos - FBITS'(1);
                        if (r_count == '0 || n_pos == first) begin
                            n_phase  = PH_STOP;
                            n_show   = SHOW_CLOSED;
                            n_closed = 1'b0;
                        end
                    end
                end
                PH_STOP: begin
                    n_timer = timer_inc;
                    if (timer_inc >= i_timing.close) begin
                        // Compact the list, dropping the current floor.
                        for (int w = 0; w < QDEPTH; w++) begin
                            if (CW'(w) < r_count && r_list[w] != r_pos) begin
                                n_list[wr[IW-1:0]] = r_list[w];
                                wr = wr + CW'(1);
                            end
                        end
                        n_count  = wr;
                        n_timer  = '0;
                        n_closed = 1'b0;
                        n_show   = SHOW_OPEN;
                        if (wr == '0 || n_list[0] == r_pos) n_phase = PH_IDLE;
                        else if (n_list[0] < r_pos)         n_phase = PH_START_DOWN;
                        else                                n_phase = PH_START_UP;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= FBITS'(1);
            r_show   <= SHOW_OPEN;
            r_timer  <= '0;
            r_closed <= 1'b0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_show   <= n_show;
            r_timer  <= n_timer;
            r_closed <= n_closed;
            r_count  <= n_count;
        end
    end

    // Request list storage.
    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    assign o_phase    = r_phase;
    assign o_position = r_pos;
    assign o_show     = r_show;
    assign o_count    = r_count;
endmodule
`default_nettype wire

FILE: sv/two_car_elevator_controller_top.sv
// Top level of the two-car elevator controller.
`timescale 1ns / 1ps
`default_nettype none
// Usage: pulse start with a transaction (tick, hall call or car call) on
// i_kind, i_car, i_call_floor and i_call_direction. busy is always low, so a
// transaction is taken in every cycle. In the next cycle o_valid strobes for one
// cycle with the assigned car, the accepted flag and the status of both cars
// after the transaction. Throughput is one transaction per cycle: the whole
// update is one pass of combinational logic from the car registers into the
// car and result registers.
// The receiver cannot stall; each result shows for exactly one cycle.
// Timer settings are written through i_cfg_we, i_cfg_index and i_cfg_data,
// at any time while no transaction is in flight.
// Synchronous reset puts both cars idle at floor 1, doors open, with empty
// request lists, and restores the default timer settings.
module two_car_elevator_controller_top #(
    parameter int QUEUE_DEPTH = tcec_pkg::QUEUE_DEPTH,
    parameter int FLOOR_BITS  = tcec_pkg::FLOOR_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_kind,
    input  wire         i_car,
    input  wire  [3:0]  i_call_floor,
    input  wire  [1:0]  i_call_direction,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_assigned_car,
    output logic        o_accepted,
    output logic [3:0]  o_car0_floor,
    output logic [1:0]  o_car0_display,
    output logic [3:0]  o_car0_pending,
    output logic [3:0]  o_car1_floor,
    output logic [1:0]  o_car1_display,
    output logic [3:0]  o_car1_pending
);
    import tcec_pkg::*;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_timing              r_timing;
    t_car_op              op0, op1;
    logic [FLOOR_BITS-1:0] floor_in;
    logic                 added0, added1;
    t_phase               ph0, ph1;
    logic [FLOOR_BITS-1:0] pos0, pos1;
    logic [1:0]           show0, show1;
    logic [CW-1:0]        cnt0, cnt1;
    logic                 take0, take1, target;
    logic                 is_call, r_valid, r_assigned, r_accepted;

    assign busy     = 1'b0;
    assign floor_in = FLOOR_BITS'(i_call_floor);
    assign is_call  = start && (i_kind == KIND_HALL || i_kind == KIND_CAR);

    // Hall and car call dispatch, and the tick operation for both cars.
    always_comb begin
        take0 = (ph0 == PH_IDLE)
            || (i_call_direction == DIR_UP && (ph0 == PH_GO_UP || ph0 == PH_START_UP)
                && floor_in > pos0)
            || (i_call_direction == DIR_DOWN
                && (ph0 == PH_GO_DOWN || ph0 == PH_START_DOWN) && floor_in < pos0);
        take1 = (ph1 == PH_IDLE)
            || (i_call_direction == DIR_UP && (ph1 == PH_GO_UP || ph1 == PH_START_UP)
                && floor_in > pos1)
            || (i_call_direction == DIR_DOWN
                && (ph1 == PH_GO_DOWN || ph1 == PH_START_DOWN) && floor_in < pos1);
        if (i_kind == KIND_CAR) target = i_car;
        else if (take0)         target = 1'b0;
        else if (take1)         target = 1'b1;
        else                    target = (cnt0 > cnt1);
        op0.tick = start && i_kind == KIND_TICK;
        op1.tick = op0.tick;
        op0.add  = is_call && !target;
        op1.add  = is_call && target;
    end

    tcec_car #(.QDEPTH(QUEUE_DEPTH), .FBITS(FLOOR_BITS)) u_car0 (
        .i_clk, .i_rst_n, .i_timing(r_timing), .i_op(op0), .i_floor(floor_in),
        .o_added(added0), .o_phase(ph0), .o_position(pos0), .o_show(show0),
        .o_count(cnt0)
    );
    tcec_car #(.QDEPTH(QUEUE_DEPTH), .FBITS(FLOOR_BITS)) u_car1 (
        .i_clk, .i_rst_n, .i_timing(r_timing), .i_op(op1), .i_floor(floor_in),
        .o_added(added1), .o_phase(ph1), .o_position(pos1), .o_show(show1),
        .o_count(cnt1)
    );

    // Configuration registers and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing <= '{travel: TRAVEL_RESET, open: OPEN_RESET, close: CLOSE_RESET};
            r_valid  <= 1'b0;
        end else begin
            r_valid <= start;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TRAVEL: r_timing.travel <= i_cfg_data;
                    CFG_OPEN:   r_timing.open   <= i_cfg_data;
                    CFG_CLOSE:  r_timing.close  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result fields of the last transaction.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_assigned <= is_call && target;
            r_accepted <= is_call && (target ? added1 : added0);
        end
    end

    assign o_valid        = r_valid;
    assign o_assigned_car = r_assigned;
    assign o_accepted     = r_accepted;
    assign o_car0_floor   = 4'(pos0);
    assign o_car0_display = show0;
    assign o_car0_pending = 4'(cnt0);
    assign o_car1_floor   = 4'(pos1);
    assign o_car1_display = show1;
    assign o_car1_pending = 4'(cnt1);
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the two-car elevator controller.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import tcec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Status of both cars as seen after one transaction.
    typedef struct packed {
        logic       assigned_car;
        logic       accepted;
        logic [3:0] car0_floor;
        logic [1:0] car0_display;
        logic [3:0] car0_pending;
        logic [3:0] car1_floor;
        logic [1:0] car1_display;
        logic [3:0] car1_pending;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = KIND_TICK;
    logic        i_car = 1'b0;
    logic [3:0]  i_call_floor = '0;
    logic [1:0]  i_call_direction = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_TRAVEL;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        o_assigned_car;
    logic        o_accepted;
    logic [3:0]  o_car0_floor;
    logic [1:0]  o_car0_display;
    logic [3:0]  o_car0_pending;
    logic [3:0]  o_car1_floor;
    logic [1:0]  o_car1_display;
    logic [3:0]  o_car1_pending;

    two_car_elevator_controller_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_car(i_car), .i_call_floor(i_call_floor),
        .i_call_direction(i_call_direction), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .o_assigned_car(o_assigned_car), .o_accepted(o_accepted),
        .o_car0_floor(o_car0_floor), .o_car0_display(o_car0_display),
        .o_car0_pending(o_car0_pending), .o_car1_floor(o_car1_floor),
        .o_car1_display(o_car1_display), .o_car1_pending(o_car1_pending)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the controller state.
    t_phase      car_ph [2];
    logic [3:0]  car_pos [2];
    logic [1:0]  car_show [2];
    logic [15:0] car_tmr [2];
    logic        car_doors_shut [2];
    logic [3:0]  stop_list [2][QUEUE_DEPTH];
    int          stop_count [2];
    logic [15:0] travel_set, open_set, close_set;

    t_status expected_status [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void car_enter(int c, t_phase p, logic [1:0] s);
        car_ph[c] = p;
        car_show[c] = s;
        car_tmr[c] = '0;
        car_doors_shut[c] = 1'b0;
    endfunction

    // Depart toward the first listed floor, or rest with doors open.
    function automatic void car_head_out(int c);
        if (stop_count[c] == 0 || stop_list[c][0] == car_pos[c])
            car_enter(c, PH_IDLE, SHOW_OPEN);
        else if (stop_list[c][0] < car_pos[c])
            car_enter(c, PH_START_DOWN, SHOW_OPEN);
        else
            car_enter(c, PH_START_UP, SHOW_OPEN);
    endfunction

    function automatic bit car_add_stop(int c, logic [3:0] fl);
        int n;
        n = stop_count[c];
        for (int i = 0; i < n; i++)
            if (stop_list[c][i] == fl) return 1'b0;
        if (n == 0) begin
            // A call at the floor of a resting car is served on the spot.
            if (fl == car_pos[c]) begin
                car_enter(c, PH_IDLE, SHOW_OPEN);
                return 1'b1;
            end
            stop_list[c][0] = fl;
            stop_count[c] = 1;
            car_head_out(c);
            return 1'b1;
        end
        if (n >= QUEUE_DEPTH) return 1'b0;
        stop_list[c][n] = fl;
        stop_count[c] = n + 1;
        return 1'b1;
    endfunction

    function automatic bit car_takes_hall(int c, logic [3:0] fl, logic [1:0] dir);
        if (car_ph[c] == PH_IDLE) return 1'b1;
        if (dir == DIR_UP && (car_ph[c] == PH_GO_UP || car_ph[c] == PH_START_UP)
            && fl > car_pos[c]) return 1'b1;
        if (dir == DIR_DOWN && (car_ph[c] == PH_GO_DOWN || car_ph[c] == PH_START_DOWN)
            && fl < car_pos[c]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void car_advance(int c);
        int r;
        if (car_ph[c] == PH_IDLE) begin
            car_show[c] = SHOW_OPEN;
            car_tmr[c] = '0;
            return;
        end
        car_tmr[c] = car_tmr[c] + 16'd1;
        case (car_ph[c])
            PH_START_UP, PH_START_DOWN: begin
                if (!car_doors_shut[c]) begin
                    if (car_tmr[c] >= open_set) begin
                        car_doors_shut[c] = 1'b1;
                        car_tmr[c] = '0;
                        car_show[c] = SHOW_CLOSED;
                    end
                end else if (car_tmr[c] >= close_set) begin
                    if (car_ph[c] == PH_START_UP) car_enter(c, PH_GO_UP, SHOW_UP);
                    else car_enter(c, PH_GO_DOWN, SHOW_DOWN);
                end
            end
            PH_GO_UP, PH_GO_DOWN: begin
                if (car_tmr[c] >= travel_set) begin
                    car_tmr[c] = '0;
                    if (car_ph[c] == PH_GO_UP) car_pos[c] = car_pos[c] + 4'd1;
                    else car_pos[c] = car_pos[c] - 4'd1;
                    if (stop_count[c] == 0 || car_pos[c] == stop_list[c][0])
                        car_enter(c, PH_STOP, SHOW_CLOSED);
                end
            end
            default: begin
                // Arrival: drop this floor from the list and move on.
                if (car_tmr[c] >= close_set) begin
                    r = 0;
                    for (int w = 0; w < stop_count[c]; w++)
                        if (stop_list[c][w] != car_pos[c]) begin
                            stop_list[c][r] = stop_list[c][w];
                            r++;
                        end
                    stop_count[c] = r;
                    car_head_out(c);
                end
            end
        endcase
    endfunction

    function automatic t_status group_step(logic [1:0] kind, logic car, logic [3:0] fl,
                                           logic [1:0] dir);
        t_status s;
        s = '0;
        if (kind == KIND_TICK) begin
            car_advance(0);
            car_advance(1);
        end else if (kind == KIND_HALL) begin
            if (car_takes_hall(0, fl, dir)) s.assigned_car = 1'b0;
            else if (car_takes_hall(1, fl, dir)) s.assigned_car = 1'b1;
            else s.assigned_car = stop_count[0] > stop_count[1];
            s.accepted = car_add_stop(int'(s.assigned_car), fl);
        end else if (kind == KIND_CAR) begin
            s.assigned_car = car;
            s.accepted = car_add_stop(int'(car), fl);
        end
        s.car0_floor = car_pos[0];
        s.car0_display = car_show[0];
        s.car0_pending = 4'(stop_count[0]);
        s.car1_floor = car_pos[1];
        s.car1_display = car_show[1];
        s.car1_pending = 4'(stop_count[1]);
        return s;
    endfunction

    function automatic void group_reset();
        travel_set = TRAVEL_RESET;
        open_set = OPEN_RESET;
        close_set = CLOSE_RESET;
        for (int c = 0; c < 2; c++) begin
            car_enter(c, PH_IDLE, SHOW_OPEN);
            car_pos[c] = 4'd1;
            stop_count[c] = 0;
            for (int i = 0; i < QUEUE_DEPTH; i++) stop_list[c][i] = '0;
        end
    endfunction

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_status e;
        if (i_rst_n && o_valid) begin
            if (expected_status.size() == 0) begin
                $error("result transaction with no expectation");
                error_count++;
            end else begin
                e = expected_status.pop_front();
                if (o_assigned_car !== e.assigned_car) begin
                    $error("assigned_car exp %0d got %0d", e.assigned_car, o_assigned_car);
                    error_count++;
                end
                if (o_accepted !== e.accepted) begin
                    $error("accepted exp %0d got %0d", e.accepted, o_accepted);
                    error_count++;
                end
                if (o_car0_floor !== e.car0_floor) begin
                    $error("car0_floor exp %0d got %0d", e.car0_floor, o_car0_floor);
                    error_count++;
                end
                if (o_car0_display !== e.car0_display) begin
                    $error("car0_display exp %0d got %0d", e.car0_display, o_car0_display);
                    error_count++;
                end
                if (o_car0_pending !== e.car0_pending) begin
                    $error("car0_pending exp %0d got %0d", e.car0_pending, o_car0_pending);
                    error_count++;
                end
                if (o_car1_floor !== e.car1_floor) begin
                    $error("car1_floor exp %0d got %0d", e.car1_floor, o_car1_floor);
                    error_count++;
                end
                if (o_car1_display !== e.car1_display) begin
                    $error("car1_display exp %0d got %0d", e.car1_display, o_car1_display);
                    error_count++;
                end
                if (o_car1_pending !== e.car1_pending) begin
                    $error("car1_pending exp %0d got %0d", e.car1_pending, o_car1_pending);
                    error_count++;
                end
            end
        end
    end

    // Issue one transaction, with a random idle gap in front of it.
    task automatic send_request(logic [1:0] kind, logic car, logic [3:0] fl,
                                logic [1:0] dir);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_kind = kind;
        i_car = car;
        i_call_floor = fl;
        i_call_direction = dir;
        do @(posedge i_clk); while (busy);
        expected_status.push_back(group_step(kind, car, fl, dir));
    endtask

    // Let every expected result arrive, leaving the controller idle.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_timing(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_TRAVEL) travel_set = val;
        else if (idx == CFG_OPEN) open_set = val;
        else if (idx == CFG_CLOSE) close_set = val;
    endtask

    task automatic set_timing(logic [15:0] tr, logic [15:0] op, logic [15:0] cl);
        drain();
        write_timing(CFG_TRAVEL, tr);
        write_timing(CFG_OPEN, op);
        write_timing(CFG_CLOSE, cl);
    endtask

    // Default timers: calls are taken but nothing moves yet.
    task automatic test_default_timing();
        send_request(KIND_TICK, 1'b0, 4'd0, 2'd0);
        send_request(KIND_HALL, 1'b1, 4'd15, DIR_UP);
        send_request(KIND_TICK, 1'b1, 4'd3, 2'd3);
    endtask

    // Directed corners: own floor, duplicates, full list, every kind and direction.
    task automatic test_directed_calls();
        send_request(KIND_CAR, 1'b1, 4'd1, 2'd0);
        send_request(2'd3, 1'b1, 4'd9, 2'd3);
        for (int f = 2; f <= 10; f++) send_request(KIND_CAR, 1'b0, 4'(f), 2'd0);
        send_request(KIND_CAR, 1'b0, 4'd4, 2'd0);
        send_request(KIND_HALL, 1'b0, 4'd0, DIR_DOWN);
        send_request(KIND_HALL, 1'b0, 4'd15, DIR_UP);
        send_request(KIND_HALL, 1'b0, 4'd12, 2'd3);
        send_request(KIND_HALL, 1'b1, 4'd14, 2'd0);
        for (int k = 0; k < 6; k++) send_request(KIND_TICK, 1'b0, 4'd0, 2'd0);
        send_request(KIND_HALL, 1'b0, 4'd13, DIR_UP);
        send_request(KIND_HALL, 1'b1, 4'd0, DIR_DOWN);
    endtask

    // Random traffic: mostly ticks so the cars keep moving between calls.
    task automatic test_random_traffic(int count, int gap_pct, bit pause_once);
        int sel;
        idle_pct = gap_pct;
        for (int n = 0; n < count; n++) begin
            if (pause_once && n == count / 2) drain();
            sel = $urandom_range(99);
            if (sel < 60)
                send_request(KIND_TICK, 1'($urandom), 4'($urandom), 2'($urandom));
            else if (sel < 80)
                send_request(KIND_HALL, 1'($urandom), 4'($urandom), 2'($urandom));
            else if (sel < 98)
                send_request(KIND_CAR, 1'($urandom), 4'($urandom), 2'($urandom));
            else
                send_request(2'd3, 1'($urandom), 4'($urandom), 2'($urandom));
        end
    endtask

    initial begin
        group_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_pct = 24;
        test_default_timing();
        set_timing(16'd2, 16'd1, 16'd1);
        test_directed_calls();
        test_random_traffic(250, 24, 1'b1);
        set_timing(16'd0, 16'd0, 16'd0);
        test_random_traffic(120, 86, 1'b0);
        set_timing(16'd3, 16'd2, 16'd2);
        write_timing(2'd3, 16'hFFFF);
        test_random_traffic(250, 86, 1'b0);
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(30, 0, 1'b0);
        set_timing(16'd1, 16'd1, 16'd3);
        test_random_traffic(150, 0, 1'b0);

        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
